// ----- design/tcd_pkg.sv -----
// Shared types and constants of the tile change detector.
`timescale 1ns / 1ps

package tcd_pkg;

    // Store geometry.
    localparam int MAX_TILES      = 256;
    localparam int MAX_TILE_WORDS = 512;
    localparam int FRAME_DEPTH    = MAX_TILES * MAX_TILE_WORDS;
    localparam int FS_AW          = $clog2(FRAME_DEPTH);

    // Field widths.
    localparam int TILE_W  = 8;
    localparam int WORD_W  = 9;
    localparam int PIX_W   = 64;
    localparam int BE_W    = PIX_W / 8;
    localparam int AGE_W   = 8;
    localparam int WPT_W   = 10;
    localparam int CNT_W   = 9;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS_PER_TILE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT     = CFG_IDX_W'(1);
    localparam logic [WPT_W-1:0]     CFG_WPT_RESET      = WPT_W'(512);
    localparam logic [CNT_W-1:0]     CFG_COUNT_RESET    = CNT_W'(0);

    // Age value given to a tile that changed.
    localparam logic [AGE_W-1:0] AGE_CHANGED = AGE_W'(8'h80);

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Result queue at the output.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic [TILE_W-1:0] tile_index;
        logic [WORD_W-1:0] word_index;
        logic [PIX_W-1:0]  pixel_word;
        logic [BE_W-1:0]   byte_enable;
        logic              last_word;
    } t_tcd_in;

    typedef struct packed {
        logic [TILE_W-1:0] done_tile;
        logic              changed;
        logic [AGE_W-1:0]  new_age;
    } t_tcd_out;

    // One classified word waiting for the back part.
    typedef struct packed {
        logic [FS_AW-1:0]  addr;
        logic [TILE_W-1:0] tile;
        logic [PIX_W-1:0]  pix;
        logic [BE_W-1:0]   be;
        logic              wr_ok;
        logic              last;
    } t_tcd_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_tcd_q_status;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_tcd_back_status;

endpackage

// ----- design/tcd_queue.sv -----
// Short word queue between the classifying front and the store back end.
`timescale 1ns / 1ps

module tcd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcd_pkg::t_tcd_work i_push_data,
    input  logic              i_pop,
    output tcd_pkg::t_tcd_work o_head,
    output tcd_pkg::t_tcd_q_status o_status
);
    import tcd_pkg::*;

    t_tcd_work         r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW:0]     n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

// ----- design/tcd_front.sv -----
// Configuration registers and word classification ahead of the queue.
`timescale 1ns / 1ps

module tcd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tcd_pkg::t_tcd_in             i_in_data,
    input  tcd_pkg::t_tcd_q_status       i_q_status,
    input  tcd_pkg::t_tcd_back_status    i_back_status,
    output logic                         o_push,
    output tcd_pkg::t_tcd_work           o_push_data
);
    import tcd_pkg::*;

    localparam int PROD_W = TILE_W + WPT_W;

    logic [WPT_W-1:0]  r_words_per_tile;
    logic [CNT_W-1:0]  r_tile_count;
    logic [WPT_W-1:0]  wpt_eff;
    logic [CNT_W-1:0]  limit;
    logic [PROD_W-1:0] prod;
    logic              tile_in_use;
    logic              word_in_tile;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_per_tile <= CFG_WPT_RESET;
            r_tile_count     <= CFG_COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WORDS_PER_TILE: r_words_per_tile <= i_cfg_data[WPT_W-1:0];
                REG_TILE_COUNT:     r_tile_count     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Oversized settings saturate at the store geometry.
    assign wpt_eff = (r_words_per_tile > WPT_W'(MAX_TILE_WORDS)) ?
                     WPT_W'(MAX_TILE_WORDS) : r_words_per_tile;
    assign limit   = (r_tile_count > CNT_W'(MAX_TILES)) ? CNT_W'(MAX_TILES) : r_tile_count;

    assign tile_in_use  = (CNT_W'(i_in_data.tile_index) < limit);
    assign word_in_tile = (WPT_W'(i_in_data.word_index) < wpt_eff);

    assign prod = {{WPT_W{1'b0}}, i_in_data.tile_index} * {{TILE_W{1'b0}}, wpt_eff};

    assign o_in_ready = !i_q_status.full && !i_back_status.clearing;
    // Words of tiles beyond the count in use are dropped right here.
    assign o_push     = i_in_valid && o_in_ready && tile_in_use;

    always_comb begin
        o_push_data.addr  = FS_AW'(prod + PROD_W'(i_in_data.word_index));
        o_push_data.tile  = i_in_data.tile_index;
        o_push_data.pix   = i_in_data.pixel_word;
        o_push_data.be    = i_in_data.byte_enable;
        o_push_data.wr_ok = word_in_tile;
        o_push_data.last  = i_in_data.last_word;
    end

endmodule

// ----- design/tcd_back.sv -----
// Frame and age stores, compare and update pipeline, and the result queue.
`timescale 1ns / 1ps

module tcd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcd_pkg::t_tcd_work        i_head,
    input  tcd_pkg::t_tcd_q_status    i_q_status,
    output tcd_pkg::t_tcd_back_status o_status,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tcd_pkg::t_tcd_out         o_out_data
);
    import tcd_pkg::*;

    localparam int OUT_CW = OUT_AW + 2;

    function automatic logic [PIX_W-1:0] lane_mask(input logic [BE_W-1:0] be);
        logic [PIX_W-1:0] m;
        m = '0;
        for (int k = 0; k < BE_W; k++) begin
            m[8*k +: 8] = {8{be[k]}};
        end
        return m;
    endfunction

    // Stores.
    logic [PIX_W-1:0] r_fs_mem  [FRAME_DEPTH];
    logic [AGE_W-1:0] r_age_mem [MAX_TILES];

    // Clearing sweep.
    logic             r_clearing;
    logic [FS_AW-1:0] r_clr_addr;

    // Second stage.
    logic              r_s2_valid;
    t_tcd_work         r_s2;
    logic [PIX_W-1:0]  r_fs_rdata, r_fs_fwd_data;
    logic              r_fs_fwd_hit;
    logic [AGE_W-1:0]  r_age_rdata, r_age_fwd_data;
    logic              r_age_fwd_hit;
    logic              r_diff;

    // Result queue.
    t_tcd_out          r_out_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] r_out_wr, r_out_rd;
    logic [OUT_AW:0]   r_out_cnt;

    logic              pop;
    logic              credit_ok;
    logic [PIX_W-1:0]  mask, old_word, merged;
    logic              word_diff, acc;
    logic [AGE_W-1:0]  old_age, new_age;
    logic              fs_we, age_we;
    logic              out_push, out_pop;
    logic [FS_AW-1:0]  fs_waddr;
    logic [PIX_W-1:0]  fs_wdata;
    logic              fs_wen;
    logic [TILE_W-1:0] age_waddr;
    logic [AGE_W-1:0]  age_wdata;
    logic              age_wen;

    // A last word may enter only if its result is sure to find room.
    assign credit_ok = (OUT_CW'(r_out_cnt) + OUT_CW'(r_s2_valid && r_s2.last))
                       < OUT_CW'(OUT_DEPTH);
    assign pop = !r_clearing && !i_q_status.empty && (!i_head.last || credit_ok);

    assign o_status.clearing = r_clearing;
    assign o_status.pop      = pop;

    // Read-modify-write of the word now in the second stage.
    assign mask      = lane_mask(r_s2.be);
    assign old_word  = r_fs_fwd_hit ? r_fs_fwd_data : r_fs_rdata;
    assign word_diff = r_s2.wr_ok && (((old_word ^ r_s2.pix) & mask) != '0);
    assign merged    = (old_word & ~mask) | (r_s2.pix & mask);
    assign acc       = r_diff | word_diff;
    assign fs_we     = r_s2_valid && r_s2.wr_ok;

    assign old_age = r_age_fwd_hit ? r_age_fwd_data : r_age_rdata;
    always_comb begin
        if (acc) begin
            new_age = AGE_CHANGED;
        end else if (old_age[AGE_W-1]) begin
            new_age = old_age;
        end else begin
            new_age = old_age + 1'b1;
        end
    end
    assign age_we = r_s2_valid && r_s2.last;

    // Write ports are shared with the clearing sweep.
    assign fs_wen    = r_clearing || fs_we;
    assign fs_waddr  = r_clearing ? r_clr_addr : r_s2.addr;
    assign fs_wdata  = r_clearing ? '0 : merged;
    assign age_wen   = r_clearing ? (r_clr_addr < FS_AW'(MAX_TILES)) : age_we;
    assign age_waddr = r_clearing ? r_clr_addr[TILE_W-1:0] : r_s2.tile;
    assign age_wdata = r_clearing ? '0 : new_age;

    always_ff @(posedge i_clk) begin
        r_fs_rdata <= r_fs_mem[i_head.addr];
        if (fs_wen) begin
            r_fs_mem[fs_waddr] <= fs_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_age_rdata <= r_age_mem[i_head.tile];
        if (age_wen) begin
            r_age_mem[age_waddr] <= age_wdata;
        end
    end

    // The store read misses a write landing in the same cycle, so that value is forwarded.
    always_ff @(posedge i_clk) begin
        r_s2           <= i_head;
        r_fs_fwd_hit   <= fs_we && (i_head.addr == r_s2.addr);
        r_fs_fwd_data  <= merged;
        r_age_fwd_hit  <= age_we && (i_head.tile == r_s2.tile);
        r_age_fwd_data <= new_age;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s2_valid <= 1'b0;
            r_diff     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == FS_AW'(FRAME_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s2_valid <= pop;
            if (r_s2_valid) begin
                r_diff <= r_s2.last ? 1'b0 : acc;
            end
        end
    end

    assign out_push = r_s2_valid && r_s2.last;
    assign out_pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (out_push) begin
                r_out_wr <= r_out_wr + 1'b1;
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + 1'b1;
            end
            if (out_push && !out_pop) begin
                r_out_cnt <= r_out_cnt + 1'b1;
            end else if (!out_push && out_pop) begin
                r_out_cnt <= r_out_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out_mem[r_out_wr].done_tile <= r_s2.tile;
            r_out_mem[r_out_wr].changed   <= acc;
            r_out_mem[r_out_wr].new_age   <= new_age;
        end
    end

    assign o_out_valid = (r_out_cnt != '0);
    assign o_out_data  = r_out_mem[r_out_rd];

endmodule

// ----- design/tile_change_detector_core.sv -----
// Top level of the tile change detector: front, word queue and store back end.
`timescale 1ns / 1ps

// Usage. Pixel words enter on the i_in_* channel, one word per handshake, each
// carrying its tile number, word index, byte enables and a last flag. Every
// enabled byte of a word inside the tile is compared with the frame store copy
// and then written over it. The word flagged last closes the tile and yields one
// result word on the o_out_* channel: tile number, changed flag and updated age.
// Words of tiles at or beyond the configured tile count are dropped silently.
// The i_cfg_* channel writes words_per_tile (index 0) and tile_count (index 1);
// it is always ready and should only be used while no tile is in flight.
// Throughput is one word per clock while the word queue is not full and no
// sweep runs. That rate is set by the frame store's read-modify-write, which
// writes each word in the cycle after its read, with the value being written
// forwarded to a read of the same address. A result passes through the word
// queue, the second stage and the result queue before it can be taken. The
// four-entry result queue absorbs a stalled receiver; once it cannot promise
// room, last words wait in the four-entry word queue and the input deasserts
// ready when that queue fills. After reset a sweep clears the frame and age
// stores, one frame word per cycle, during which input ready stays low.
module tile_change_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tcd_pkg::t_tcd_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tcd_pkg::t_tcd_out             o_out_data
);
    import tcd_pkg::*;

    t_tcd_q_status    q_status;
    t_tcd_back_status back_status;
    t_tcd_work        push_data;
    t_tcd_work        head;
    logic             push;

    // Front: holds the configuration and turns each word into a store access.
    tcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_q_status   (q_status),
        .i_back_status(back_status),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    // The queue lets the front keep taking words while the back waits on output room.
    tcd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .i_pop      (back_status.pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    // Back: compares, updates the stores and keeps the pending results.
    tcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_status   (back_status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // No word is taken while the stores are still being cleared.
    a_no_input_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        back_status.clearing |-> !o_in_ready
    ) else $error("input accepted during the clearing sweep");

    // No result can exist before the sweep has finished.
    a_no_output_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        back_status.clearing |-> !o_out_valid
    ) else $error("result shown during the clearing sweep");

    // The back end only takes a word that the queue really holds.
    a_pop_not_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        back_status.pop |-> !q_status.empty
    ) else $error("word queue popped while empty");

    // When the sweep ends the queue has seen no word yet.
    a_queue_empty_after_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $fell(back_status.clearing) |-> q_status.empty
    ) else $error("word queue filled during the clearing sweep");

endmodule

// ----- test/tcd_checker.sv -----
// Checker that predicts the tile change detector's results and compares them on the output.
`timescale 1ns / 1ps

module tcd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  tcd_pkg::t_tcd_in               i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  tcd_pkg::t_tcd_out              i_out_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import tcd_pkg::*;

    // Shadow of the block's state and registers.
    logic [PIX_W-1:0] frame_copy [FRAME_DEPTH];
    logic [AGE_W-1:0] age_copy [MAX_TILES];
    logic             diff_seen;
    logic [WPT_W-1:0] wpt_setting;
    logic [CNT_W-1:0] count_setting;

    t_tcd_out expected_results [$];
    int       failures = 0;

    assign o_fail_count = failures;

    function automatic logic [PIX_W-1:0] lane_bits(input logic [BE_W-1:0] be);
        logic [PIX_W-1:0] m;
        m = '0;
        for (int k = 0; k < BE_W; k++) begin
            if (be[k]) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Compares and stores one word; a last word of a tile in use queues a result.
    task automatic track_word(input t_tcd_in w);
        int               limit;
        int               span;
        int               addr;
        logic [PIX_W-1:0] mask;
        logic [PIX_W-1:0] old;
        logic [AGE_W-1:0] age;
        t_tcd_out         res;
        limit = (int'(count_setting) > MAX_TILES) ? MAX_TILES : int'(count_setting);
        span  = (int'(wpt_setting) > MAX_TILE_WORDS) ? MAX_TILE_WORDS : int'(wpt_setting);
        if (int'(w.tile_index) < limit) begin
            if (int'(w.word_index) < span) begin
                addr = int'(w.tile_index) * span + int'(w.word_index);
                mask = lane_bits(w.byte_enable);
                old  = frame_copy[addr];
                if (((old ^ w.pixel_word) & mask) != '0) begin
                    diff_seen = 1'b1;
                end
                frame_copy[addr] = (old & ~mask) | (w.pixel_word & mask);
            end
            if (w.last_word) begin
                age = age_copy[w.tile_index];
                if (diff_seen) begin
                    age = AGE_CHANGED;
                end else if (!age[AGE_W-1]) begin
                    age = age + 1'b1;
                end
                age_copy[w.tile_index] = age;
                res.done_tile = w.tile_index;
                res.changed   = diff_seen;
                res.new_age   = age;
                expected_results.push_back(res);
                diff_seen = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_tcd_out want;
        if (!i_rst_n) begin
            foreach (frame_copy[a]) frame_copy[a] = '0;
            foreach (age_copy[t]) age_copy[t] = '0;
            diff_seen     = 1'b0;
            wpt_setting   = CFG_WPT_RESET;
            count_setting = CFG_COUNT_RESET;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: done_tile %0d changed %0d new_age 0x%02h",
                           i_out_data.done_tile, i_out_data.changed, i_out_data.new_age);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.done_tile !== want.done_tile) begin
                        $error("done_tile: expected %0d, got %0d",
                               want.done_tile, i_out_data.done_tile);
                        failures++;
                    end
                    if (i_out_data.changed !== want.changed) begin
                        $error("changed: expected %0d, got %0d",
                               want.changed, i_out_data.changed);
                        failures++;
                    end
                    if (i_out_data.new_age !== want.new_age) begin
                        $error("new_age: expected 0x%02h, got 0x%02h",
                               want.new_age, i_out_data.new_age);
                        failures++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WORDS_PER_TILE: wpt_setting = i_cfg_data[WPT_W-1:0];
                    REG_TILE_COUNT:     count_setting = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                track_word(i_in_data);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- test/testbench.sv -----
// Testbench top: stimulus for the tile change detector, receiver pacing and the verdict.
`timescale 1ns / 1ps

module testbench;
    import tcd_pkg::*;

    // The limit lies far above what the clearing sweep after reset and a full run
    // need together, so it only trips on a hung block.
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RESET_CYCLES  = 6;
    // Lets words that give no result run dry after the last result, with a wide margin.
    localparam int SETTLE_CYCLES = 16;
    // Length of the one long receiver hold-off that fills the block's queues.
    localparam int HOLD_CYCLES   = 400;
    // Number of words sent before the idling pattern moves on.
    localparam int CHUNK         = 40;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_tcd_in               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_tcd_out              out_data;

    int fail_count;
    int pending;

    // Stimulus pacing. The sender's idle rate is only used by the stimulus
    // process; the receiver's rate and the hold-off request cross into the
    // receiver process and are therefore written with nonblocking assignments.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_asks      = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int mode_ctr       = 0;
    int cycle_count    = 0;

    // Register values last written, used to shape well-formed tiles.
    int cur_wpt   = 512;
    int cur_count = 0;

    tile_change_detector_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    tcd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock, first rising edge at 10 ns.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[tile_change_detector_core] ERROR");
            $finish;
        end
    end

    // Receiver. It stalls at the current random rate, except during a long
    // hold-off, which it counts down itself while the sender keeps going. A new
    // hold-off starts whenever the stimulus raises the request count.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_taken) begin
            out_ready  <= 1'b0;
            hold_taken <= hold_asks;
            hold_left  <= HOLD_CYCLES;
        end else begin
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic t_tcd_in make_word(input logic [TILE_W-1:0] tile,
                                          input logic [WORD_W-1:0] widx,
                                          input logic [PIX_W-1:0]  pix,
                                          input logic [BE_W-1:0]   be,
                                          input logic              last);
        t_tcd_in w;
        w.tile_index  = tile;
        w.word_index  = widx;
        w.pixel_word  = pix;
        w.byte_enable = be;
        w.last_word   = last;
        return w;
    endfunction

    // A fixed picture: the same tile and word always give the same pixels, so
    // resending a tile unaltered reports it unchanged.
    function automatic logic [PIX_W-1:0] scene_word(input logic [TILE_W-1:0] tile,
                                                    input logic [WORD_W-1:0] widx);
        logic [PIX_W-1:0] seed;
        seed = {47'd0, tile, widx} + 64'd1;
        return seed * 64'h9E37_79B9_7F4A_7C15;
    endfunction

    // Mostly the first few tiles in use, so that tiles come back often; now and
    // then any tile in use, up to the highest, or any tile if none is in use.
    function automatic logic [TILE_W-1:0] pick_tile();
        int lim;
        int near;
        lim = (cur_count > MAX_TILES) ? MAX_TILES : cur_count;
        if (lim == 0) begin
            return TILE_W'($urandom_range(MAX_TILES - 1));
        end
        near = (lim < 6) ? lim : 6;
        if ($urandom_range(99) < 75) begin
            return TILE_W'($urandom_range(near - 1));
        end
        return TILE_W'($urandom_range(lim - 1));
    endfunction

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct = 0;
                sink_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                src_idle_pct = 64;
                sink_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                src_idle_pct = 0;
                sink_stall_pct <= 64;
            end
            default: begin
                src_idle_pct = 21;
                sink_stall_pct <= 21;
            end
        endcase
    endtask

    // Offers one word and returns at the edge that accepts it. Valid is left
    // high, so back-to-back words need no extra assignment in that time step;
    // a random gap lowers it first.
    task automatic send_word(input t_tcd_in w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Waits until every expected result has come, then lets the pipeline run
    // dry of words that give no result.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic await_cfg_accept();
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] wpt,
                               input logic [CFG_DATA_W-1:0] cnt);
        in_valid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_WORDS_PER_TILE;
        cfg_data  <= wpt;
        await_cfg_accept();
        cfg_index <= REG_TILE_COUNT;
        cfg_data  <= cnt;
        await_cfg_accept();
        cfg_valid <= 1'b0;
        cur_wpt   = int'(wpt);
        cur_count = int'(cnt[CNT_W-1:0]);
    endtask

    // Sends one well-formed tile: the words of a short tile in order, or a few
    // scattered words of a long one, the final word flagged last. Now and then
    // one word is altered, which can make this pass and the next report a change.
    task automatic send_tile(input logic [TILE_W-1:0] tile, output int n_sent);
        int               span;
        int               n;
        int               hit;
        logic [WORD_W-1:0] widx;
        logic [PIX_W-1:0]  pix;
        logic [BE_W-1:0]   be;
        span = (cur_wpt > MAX_TILE_WORDS) ? MAX_TILE_WORDS : cur_wpt;
        if (span == 0) begin
            n = 1;
        end else if (span <= 8) begin
            n = span;
        end else begin
            n = $urandom_range(6, 1);
        end
        hit = ($urandom_range(99) < 30) ? int'($urandom_range(n - 1)) : -1;
        for (int i = 0; i < n; i++) begin
            if (span == 0) begin
                widx = WORD_W'($urandom);
            end else if (span <= 8) begin
                widx = WORD_W'(i);
            end else if (i == n - 1 && $urandom_range(1) == 1) begin
                widx = WORD_W'(span - 1);
            end else begin
                widx = WORD_W'($urandom_range(span - 1));
            end
            pix = scene_word(tile, widx);
            if (i == hit) begin
                pix = pix ^ ({$urandom, $urandom} | 64'd1);
            end
            be = ($urandom_range(99) < 70) ? 8'hFF : BE_W'($urandom);
            send_word(make_word(tile, widx, pix, be, i == n - 1));
        end
        n_sent = n;
    endtask

    // Random traffic: mostly whole tiles with random content, the rest noise
    // words with every field random, which also breaks tiles off or mixes
    // them. The idling pattern rotates every few dozen words. With squeeze
    // set, the phase opens with the long receiver hold-off while the sender
    // runs flat out.
    task automatic run_phase(input int n_items, input bit squeeze);
        int sent;
        int n;
        int next_switch;
        sent        = 0;
        next_switch = 0;
        if (squeeze) begin
            set_idle(IDLE_NONE);
            hold_asks   <= hold_asks + 1;
            next_switch = 3 * CHUNK;
        end
        while (sent < n_items) begin
            if (sent >= next_switch) begin
                set_idle(t_idle_mode'(mode_ctr % 4));
                mode_ctr++;
                next_switch = sent + CHUNK;
            end
            if ($urandom_range(99) < 20) begin
                send_word(make_word(TILE_W'($urandom), WORD_W'($urandom),
                                    {$urandom, $urandom}, BE_W'($urandom),
                                    1'($urandom)));
                sent++;
            end else begin
                send_tile(pick_tile(), n);
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings have no tile in use, so these words, last one
        // included, must leave no trace. They wait out the clearing sweep.
        send_word(make_word(8'd0, 9'd0, '1, 8'hFF, 1'b0));
        send_word(make_word(8'd0, 9'd1, '1, 8'hFF, 1'b1));

        reconfigure(10'd2, 10'd256);
        // First pass over a tile changes it; the identical resend does not,
        // and since bit 7 of the age is already set, the age stays at the
        // changed value.
        send_word(make_word(8'd0, 9'd0, '1, 8'hFF, 1'b0));
        send_word(make_word(8'd0, 9'd1, 64'd0, 8'hFF, 1'b1));
        send_word(make_word(8'd0, 9'd0, '1, 8'hFF, 1'b0));
        send_word(make_word(8'd0, 9'd1, 64'd0, 8'hFF, 1'b1));
        // Highest tile, no byte enabled: compares equal, stores nothing.
        send_word(make_word(8'd255, 9'd1, '1, 8'h00, 1'b1));
        // A word past the end of the tile is skipped but still closes it.
        send_word(make_word(8'd3, 9'd511, {$urandom, $urandom}, 8'hFF, 1'b1));
        // Interleaved tiles share the accumulator: the difference in tile 4
        // shows up on the last word of tile 5.
        send_word(make_word(8'd4, 9'd0, 64'hDEAD_BEEF_0123_4567, 8'hFF, 1'b0));
        send_word(make_word(8'd5, 9'd0, 64'd0, 8'hFF, 1'b1));
        // Only the top byte enabled, then every byte but the top one.
        send_word(make_word(8'd6, 9'd1, 64'hFF00_0000_0000_0000, 8'h80, 1'b1));
        send_word(make_word(8'd6, 9'd1, 64'h00FF_FFFF_FFFF_FFFF, 8'h7F, 1'b1));

        reconfigure(10'd2, 10'd3);
        // Words of ignored tiles, last ones too, neither give a result nor clear
        // the difference that the word of tile 1 left for tile 2.
        send_word(make_word(8'd1, 9'd0, 64'h1234_5678_9ABC_DEF0, 8'hFF, 1'b0));
        send_word(make_word(8'd9, 9'd0, {$urandom, $urandom}, 8'hFF, 1'b1));
        send_word(make_word(8'd200, 9'd1, '1, 8'hFF, 1'b1));
        send_word(make_word(8'd2, 9'd0, 64'd0, 8'hFF, 1'b1));
        send_word(make_word(8'd2, 9'd0, 64'd0, 8'hFF, 1'b1));

        // No word lies inside a tile, so every result is unchanged. With two
        // tiles in use, tile 1 has never changed and its age climbs through
        // 127 to 128 and then holds.
        reconfigure(10'd0, 10'd2);
        run_phase(450, 1'b1);

        reconfigure(10'd4, 10'd16);
        run_phase(300, 1'b0);

        reconfigure(10'd1, 10'd256);
        run_phase(250, 1'b0);

        // Register values above their ranges are clamped by the block.
        reconfigure(10'h3FF, 10'h3FF);
        run_phase(100, 1'b0);

        reconfigure(10'd512, 10'd1);
        run_phase(100, 1'b0);

        reconfigure(10'd3, 10'd8);
        run_phase(250, 1'b0);

        in_valid <= 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("[tile_change_detector_core] OK");
        end else begin
            $display("[tile_change_detector_core] ERROR");
        end
        $finish;
    end

endmodule
